// File: rtl/running_mean_variance_stop_test_macros.svh
// Assertion macros shared by the checker of the running mean and variance stop test.
`ifndef RUNNING_MEAN_VARIANCE_STOP_TEST_MACROS_SVH
`define RUNNING_MEAN_VARIANCE_STOP_TEST_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RMVST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define RMVST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/rmvst_pkg.sv
// Package with widths and constants of the running mean and variance stop test.
`default_nettype none
package rmvst_pkg;
  localparam int unsigned SampleW  = 48;
  localparam int unsigned CountW   = 32;
  localparam int unsigned StdW     = 40;
  localparam int unsigned TolW     = 16;
  localparam int unsigned AccW     = 64;
  localparam int unsigned DivisorW = 33;
  localparam int unsigned RootW    = 32;
  localparam int unsigned OutDataW = 120;
  localparam logic [0:0]  RegErrorTolerance = 1'b0;
  localparam logic [0:0]  RegMinSamples     = 1'b1;
  localparam logic [TolW-1:0]   TolReset = 16'd655;
  localparam logic [CountW-1:0] MinReset = 32'd1;
endpackage
`default_nettype wire

// File: rtl/rmvst_divider.sv
// Bit-serial restoring divider: 64-bit dividend by 33-bit divisor, one quotient bit a cycle.
`default_nettype none
module rmvst_divider (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [rmvst_pkg::AccW-1:0]        dividend_i,
  input  wire logic [rmvst_pkg::DivisorW-1:0]    divisor_i,
  output logic                                   done_o,
  output logic [rmvst_pkg::AccW-1:0]             quotient_o
);
  import rmvst_pkg::*;

  logic                  active_q;
  logic [5:0]            cnt_q;
  logic [AccW-1:0]       dvd_q;
  logic [DivisorW-1:0]   dvs_q;
  logic [DivisorW:0]     rem_q;
  logic [DivisorW:0]     rem_sh;
  logic                  fits;

  assign rem_sh     = {rem_q[DivisorW-1:0], dvd_q[AccW-1]};
  assign fits       = rem_sh >= {1'b0, dvs_q};
  assign quotient_o = dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_o   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          active_q <= 1'b0;
          done_o   <= 1'b1;
        end
      end
    end
  end

  // The quotient bits shift in at the bottom as the dividend bits leave at the top.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (active_q) begin
      dvd_q <= {dvd_q[AccW-2:0], fits};
      rem_q <= fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
    end
  end
endmodule
`default_nettype wire

// File: rtl/rmvst_multiplier.sv
// Bit-serial saturating multiplier: 64 by 64 bits, one multiplier bit a cycle.
`default_nettype none
module rmvst_multiplier (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [rmvst_pkg::AccW-1:0] a_i,
  input  wire logic [rmvst_pkg::AccW-1:0] b_i,
  output logic                            done_o,
  output logic [rmvst_pkg::AccW-1:0]      product_o
);
  import rmvst_pkg::*;

  logic            active_q;
  logic [5:0]      cnt_q;
  logic [AccW-1:0] a_q;
  logic [AccW-1:0] b_q;
  logic [AccW-1:0] acc_q;
  logic            ovf_q;
  logic [AccW+1:0] sum;

  // Doubling the partial product and adding the multiplicand where the bit is set.
  assign sum       = {1'b0, acc_q, 1'b0} + {2'b00, a_q & {AccW{b_q[AccW-1]}}};
  assign product_o = ovf_q ? '1 : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_o   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          active_q <= 1'b0;
          done_o   <= 1'b1;
        end
      end
    end
  end

  // Partial products only grow, so once one overflows the result saturates.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
      ovf_q <= 1'b0;
    end else if (active_q) begin
      b_q   <= {b_q[AccW-2:0], 1'b0};
      acc_q <= sum[AccW-1:0];
      ovf_q <= ovf_q | (|sum[AccW+1:AccW]);
    end
  end
endmodule
`default_nettype wire

// File: rtl/rmvst_sqrt.sv
// Digit-serial integer square root: two radicand bits a cycle.
`default_nettype none
module rmvst_sqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [rmvst_pkg::AccW-1:0]  radicand_i,
  output logic                             done_o,
  output logic [rmvst_pkg::RootW-1:0]      root_o
);
  import rmvst_pkg::*;

  logic             active_q;
  logic [4:0]       cnt_q;
  logic [AccW-1:0]  rad_q;
  logic [RootW-1:0] root_q;
  logic [RootW+2:0] rem_q;
  logic [RootW+2:0] rem_sh;
  logic [RootW+2:0] trial;
  logic             fits;

  assign rem_sh = {rem_q[RootW:0], rad_q[AccW-1:AccW-2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fits   = rem_sh >= trial;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_o   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          active_q <= 1'b0;
          done_o   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (active_q) begin
      rad_q  <= {rad_q[AccW-3:0], 2'b00};
      root_q <= {root_q[RootW-2:0], fits};
      rem_q  <= fits ? rem_sh - trial : rem_sh;
    end
  end
endmodule
`default_nettype wire

// File: rtl/running_mean_variance_stop_test.sv
// Top level of the running mean and variance stop test with its sequencer.
// One sample is taken at a time. The first sample only sets the mean and goes straight to the
// output; every later one runs through the serial units one after another: a divide for the
// mean step, two saturating multiplies for the variance term, two divides by the count, a
// square root and a multiply for the tolerance bound. A finished result waits in an output
// register, and the next sample is taken while it waits. Configuration is written through a
// plain write port; the user must write it only while idle, as the block does not enforce it.
`default_nettype none
module running_mean_variance_stop_test (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [0:0]                    cfg_index_i,
  input  wire logic [rmvst_pkg::CountW-1:0]  cfg_data_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0: sample.
  input  wire logic [rmvst_pkg::SampleW-1:0] s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // Fields from bit 0: sample_count, running_mean, std_deviation.
  output logic [rmvst_pkg::OutDataW-1:0]     m_axis_tdata,
  // Fields from bit 0: done_res.
  output logic                               m_axis_tuser
);
  import rmvst_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StDivQ, StMulQq, StMulTerm, StDivV, StDivD, StSqrt, StRhs, StMulRhs, StOut
  } state_e;

  state_e              state_q;
  logic [TolW-1:0]     tol_q;
  logic [CountW-1:0]   min_q;
  logic [CountW-1:0]   count_q;
  logic [SampleW-1:0]  mean_q;
  logic [AccW-1:0]     var_q;
  logic [RootW-1:0]    dev_q;
  logic                dev_valid_q;
  logic                below_q;
  logic [AccW-1:0]     term_q;
  logic                done_flag_q;

  logic                div_start, div_done;
  logic [AccW-1:0]     div_dvd, div_quo;
  logic [DivisorW-1:0] div_dvs;
  logic                mul_start, mul_done;
  logic [AccW-1:0]     mul_a, mul_b, mul_p;
  logic                sqrt_start, sqrt_done;
  logic [AccW-1:0]     sqrt_rad;
  logic [RootW-1:0]    sqrt_root;

  logic                in_acc;
  logic                out_free;
  logic [SampleW:0]    diff_pos, diff_neg;
  logic [SampleW-1:0]  q_lo;
  logic [SampleW-1:0]  abs_mean;
  logic [22:0]         tol100;
  logic [AccW-1:0]     var_sub;
  logic [AccW:0]       var_sum;
  logic [AccW-1:0]     var_new;
  logic [40:0]         dev392;
  logic [AccW-1:0]     lhs;
  logic [CountW-1:0]   count_inc;
  logic [DivisorW-1:0] n_plus1;

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign diff_pos  = {s_axis_tdata[SampleW-1], s_axis_tdata} - {mean_q[SampleW-1], mean_q};
  assign diff_neg  = {mean_q[SampleW-1], mean_q} - {s_axis_tdata[SampleW-1], s_axis_tdata};
  assign q_lo      = div_quo[SampleW-1:0];
  assign abs_mean  = mean_q[SampleW-1] ? SampleW'(-mean_q) : mean_q;
  assign tol100    = {1'b0, tol_q, 6'd0} + {2'b00, tol_q, 5'd0} + {5'd0, tol_q, 2'd0};
  assign var_sub   = var_q - div_quo;
  assign var_sum   = {1'b0, var_sub} + {1'b0, term_q};
  assign var_new   = var_sum[AccW] ? '1 : var_sum[AccW-1:0];
  assign dev392    = {1'b0, dev_q, 8'd0} + {2'b00, dev_q, 7'd0} + {6'd0, dev_q, 3'd0};
  assign lhs       = {7'd0, dev392, 16'd0};
  assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
  assign n_plus1   = {1'b0, count_q} + 1'b1;

  // Operand selection for the shared serial units.
  always_comb begin
    div_start  = 1'b0;
    div_dvd    = {{(AccW-SampleW-1){1'b0}}, in_acc && (count_q != '0) &&
                  $signed(s_axis_tdata) < $signed(mean_q) ? diff_neg : diff_pos};
    div_dvs    = n_plus1;
    mul_start  = 1'b0;
    mul_a      = {{(AccW-SampleW){1'b0}}, q_lo};
    mul_b      = {{(AccW-SampleW){1'b0}}, q_lo};
    sqrt_start = 1'b0;
    sqrt_rad   = div_quo;
    unique case (state_q)
      StIdle:   div_start = in_acc && (count_q != '0);
      StDivQ:   mul_start = div_done;
      StMulQq: begin
        mul_start = mul_done;
        mul_a     = mul_p;
        mul_b     = {{(AccW-DivisorW){1'b0}}, n_plus1};
      end
      StMulTerm: begin
        div_start = mul_done;
        div_dvd   = var_q;
        div_dvs   = {1'b0, count_q};
      end
      StDivV: begin
        div_start = div_done;
        div_dvd   = var_new;
        div_dvs   = {1'b0, count_q};
      end
      StDivD:   sqrt_start = div_done;
      StRhs: begin
        mul_start = 1'b1;
        mul_a     = {{(AccW-23){1'b0}}, tol100};
        mul_b     = {{(AccW-SampleW){1'b0}}, abs_mean};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      tol_q         <= TolReset;
      min_q         <= MinReset;
      count_q       <= '0;
      mean_q        <= '0;
      var_q         <= '0;
      dev_q         <= '0;
      dev_valid_q   <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegErrorTolerance: tol_q <= cfg_data_i[TolW-1:0];
          RegMinSamples:     min_q <= cfg_data_i;
          default: ;
        endcase
      end
      // A new result loaded in StOut takes the place of the one handed over.
      if (m_axis_tvalid && m_axis_tready && (state_q != StOut)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            if (count_q == '0) begin
              // The first sample sets the mean and the count and clears done; the deviation stays undefined.
              mean_q      <= s_axis_tdata;
              count_q     <= count_inc;
              done_flag_q <= 1'b0;
              state_q     <= StOut;
            end else begin
              below_q <= $signed(s_axis_tdata) < $signed(mean_q);
              state_q <= StDivQ;
            end
          end
        end
        StDivQ: begin
          if (div_done) begin
            mean_q  <= below_q ? mean_q - q_lo : mean_q + q_lo;
            state_q <= StMulQq;
          end
        end
        StMulQq:   if (mul_done) state_q <= StMulTerm;
        StMulTerm: begin
          if (mul_done) begin
            term_q  <= mul_p;
            state_q <= StDivV;
          end
        end
        StDivV: begin
          if (div_done) begin
            var_q   <= var_new;
            state_q <= StDivD;
          end
        end
        StDivD: if (div_done) state_q <= StSqrt;
        StSqrt: begin
          if (sqrt_done) begin
            dev_q       <= sqrt_root;
            dev_valid_q <= 1'b1;
            count_q     <= count_inc;
            state_q     <= StRhs;
          end
        end
        StRhs: state_q <= StMulRhs;
        StMulRhs: begin
          if (mul_done) begin
            done_flag_q <= (count_q >= min_q) && (lhs <= mul_p);
            state_q     <= StOut;
          end
        end
        StOut: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {dev_valid_q ? {{(StdW-RootW){1'b0}}, dev_q} : {StdW{1'b1}},
                              mean_q, count_q};
            m_axis_tuser  <= done_flag_q;
            state_q       <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  rmvst_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  rmvst_multiplier u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .done_o    (mul_done),
    .product_o (mul_p)
  );

  rmvst_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sqrt_rad),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );
endmodule
`default_nettype wire

// File: rtl/rmvst_checker.sv
// Port checker for the running mean and variance stop test, bound to the top level.
`default_nettype none
`include "running_mean_variance_stop_test_macros.svh"
module rmvst_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          cfg_we_i,
  input wire logic [0:0]                    cfg_index_i,
  input wire logic [rmvst_pkg::CountW-1:0]  cfg_data_i,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic [rmvst_pkg::SampleW-1:0] s_axis_tdata,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [rmvst_pkg::OutDataW-1:0] m_axis_tdata,
  input wire logic                          m_axis_tuser
);
  import rmvst_pkg::*;

  // A result that is not taken stays offered.
  `RMVST_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  // Only one item is worked on at a time.
  `RMVST_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // Done needs a defined deviation.
  `RMVST_ASSERT_NOW(a_done_dev, m_axis_tvalid && m_axis_tuser,
                    m_axis_tdata[OutDataW-1:OutDataW-StdW] != {StdW{1'b1}})
  // Every result reports at least one sample.
  `RMVST_ASSERT_NOW(a_count_pos, m_axis_tvalid, m_axis_tdata[CountW-1:0] != '0)
endmodule

bind running_mean_variance_stop_test rmvst_checker u_rmvst_checker (.*);
`default_nettype wire
